// File: rtl/core/ordered_array_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Ordered array list engine: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define OALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/oale_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Item types, operation codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oale_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 5;
    localparam int FIELD_W = 32;
    localparam int FOUND_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [FOUND_W-1:0] found_position;
        logic [FIELD_W-1:0] removed_value;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_STEP,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_CAP,
        S_REM_STEP,
        S_REM_RD2,
        S_REM_WR,
        S_SRCH_STEP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_LEN,
        IDX_LOAD_POS,
        IDX_LOAD_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_DEC,
        RD_IDX_INC
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_VALUE
    } wr_sel_t;

    typedef struct packed {
        logic    capture;
        logic    clear_res;
        idx_op_t idx_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    take_removed;
        logic    set_ok;
        logic    set_found;
        logic    finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              ins_ok;
        logic              rem_ok;
        logic              idx_eq_pos;
        logic              rem_more;
        logic              srch_more;
        logic              match;
        logic              out_free;
    } dp_status_t;

endpackage

// File: rtl/core/oale_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered array list engine controller
// Sequences insert shifts, remove shifts and search scans over the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_array_list_engine_defines.svh"

module oale_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  oale_pkg::dp_status_t status,
    output oale_pkg::ctl_cmd_t   cmd
);

    import oale_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.kind)
                    KIND_INSERT: state_next = status.ins_ok ? S_INS_STEP : S_DONE;
                    KIND_REMOVE: state_next = status.rem_ok ? S_REM_RD : S_DONE;
                    KIND_SEARCH: state_next = S_SRCH_STEP;
                    default:     state_next = S_DONE;
                endcase
            end
            S_INS_STEP:  state_next = status.idx_eq_pos ? S_INS_PUT : S_INS_RD;
            S_INS_RD:    state_next = S_INS_WR;
            S_INS_WR:    state_next = S_INS_STEP;
            S_INS_PUT:   state_next = S_DONE;
            S_REM_RD:    state_next = S_REM_CAP;
            S_REM_CAP:   state_next = S_REM_STEP;
            S_REM_STEP:  state_next = status.rem_more ? S_REM_RD2 : S_DONE;
            S_REM_RD2:   state_next = S_REM_WR;
            S_REM_WR:    state_next = S_REM_STEP;
            S_SRCH_STEP: state_next = status.srch_more ? S_SRCH_RD : S_DONE;
            S_SRCH_RD:   state_next = S_SRCH_CMP;
            S_SRCH_CMP:  state_next = status.match ? S_DONE : S_SRCH_STEP;
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready        = 1'b0;
        cmd              = '0;
        cmd.idx_op       = IDX_HOLD;
        cmd.rd_sel       = RD_IDX;
        cmd.wr_sel       = WR_SHIFT;
        case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_DECODE:
            begin
                cmd.clear_res = 1'b1;
                case (status.kind)
                    KIND_INSERT: cmd.idx_op = IDX_LOAD_LEN;
                    KIND_REMOVE: cmd.idx_op = IDX_LOAD_POS;
                    KIND_SEARCH: cmd.idx_op = IDX_LOAD_ZERO;
                    default:     cmd.idx_op = IDX_HOLD;
                endcase
            end
            S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX_DEC;
            end
            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_DEC;
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_VALUE;
                cmd.set_ok = 1'b1;
            end
            S_REM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
            end
            S_REM_CAP:
            begin
                cmd.take_removed = 1'b1;
                cmd.set_ok       = 1'b1;
            end
            S_REM_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX_INC;
            end
            S_REM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
            end
            S_SRCH_CMP:
            begin
                if (status.match)
                begin
                    cmd.set_found = 1'b1;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    `OALE_ASSERT_NEXT(a_accept_decodes, req_valid && req_ready, state_reg == S_DECODE, "accepted item did not go to decode")

endmodule

// File: rtl/core/oale_dp.sv
// ----------------------------------------------------------------------------
// Ordered array list engine datapath
// Entry memory, length, scan index, item capture and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_array_list_engine_defines.svh"

module oale_dp #(
    parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = oale_pkg::WORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oale_pkg::req_t       req,
    output oale_pkg::rsp_t       rsp,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  oale_pkg::ctl_cmd_t   cmd,
    output oale_pkg::dp_status_t status
);

    import oale_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    logic [WORD_WIDTH-1:0] mem [CAPACITY];

    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [WORD_WIDTH-1:0] key_reg;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [WORD_WIDTH-1:0] removed_reg;
    logic [FOUND_W-1:0]    found_reg;
    logic                  ok_reg;
    rsp_t                  rsp_reg;

    logic [LEN_W-1:0]      len_reg;
    logic [LEN_W-1:0]      len_next;
    logic [LEN_W-1:0]      idx_reg;
    logic [LEN_W-1:0]      idx_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic [LEN_W-1:0]      idx_inc;
    logic [LEN_W-1:0]      idx_dec;
    logic [CMP_W-1:0]      pos_cmp;
    logic [CMP_W-1:0]      len_cmp;
    logic [CMP_W-1:0]      idx_cmp;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    assign idx_inc = idx_reg + LEN_W'(1);
    assign idx_dec = idx_reg - LEN_W'(1);
    assign pos_cmp = CMP_W'(pos_reg);
    assign len_cmp = CMP_W'(len_reg);
    assign idx_cmp = CMP_W'(idx_reg);

    always_comb
    begin
        status.kind       = kind_reg;
        status.ins_ok     = (pos_cmp <= len_cmp) && (len_reg < LEN_W'(CAPACITY));
        status.rem_ok     = pos_cmp < len_cmp;
        status.idx_eq_pos = idx_cmp == pos_cmp;
        status.rem_more   = idx_inc < len_reg;
        status.srch_more  = idx_reg < len_reg;
        status.match      = rd_data_reg == key_reg;
        status.out_free   = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:     rd_addr = IDX_W'(idx_reg);
            RD_IDX_DEC: rd_addr = IDX_W'(idx_dec);
            RD_IDX_INC: rd_addr = IDX_W'(idx_inc);
            default:    rd_addr = IDX_W'(idx_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = IDX_W'(idx_reg);
                wr_data = rd_data_reg;
            end
            WR_VALUE:
            begin
                wr_addr = IDX_W'(pos_reg);
                wr_data = value_reg;
            end
            default:
            begin
                wr_addr = IDX_W'(idx_reg);
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:      idx_next = idx_reg;
            IDX_LOAD_LEN:  idx_next = len_reg;
            IDX_LOAD_POS:  idx_next = LEN_W'(pos_reg);
            IDX_LOAD_ZERO: idx_next = '0;
            IDX_INC:       idx_next = idx_inc;
            IDX_DEC:       idx_next = idx_dec;
            default:       idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.finish && ok_reg)
        begin
            if (kind_reg == KIND_INSERT)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else if (kind_reg == KIND_REMOVE)
            begin
                len_next = len_reg - LEN_W'(1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.capture)
        begin
            kind_reg  <= req.kind;
            pos_reg   <= req.position;
            value_reg <= WORD_WIDTH'(req.value);
            key_reg   <= WORD_WIDTH'(req.key);
        end
        if (cmd.clear_res)
        begin
            ok_reg      <= 1'b0;
            found_reg   <= '0;
            removed_reg <= '0;
        end
        else
        begin
            if (cmd.set_ok || cmd.set_found)
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.set_found)
            begin
                found_reg <= FOUND_W'(idx_reg);
            end
            if (cmd.take_removed)
            begin
                removed_reg <= rd_data_reg;
            end
        end
        if (cmd.finish)
        begin
            rsp_reg.ok             <= ok_reg;
            rsp_reg.found_position <= found_reg;
            rsp_reg.removed_value  <= FIELD_W'(removed_reg);
            rsp_reg.count          <= COUNT_W'(len_next);
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `OALE_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(CAPACITY), "list length above capacity")
    `OALE_ASSERT_NOW(a_wr_in_list, cmd.wr_en, idx_reg <= len_reg, "memory write past list end")
    `OALE_ASSERT_NEXT(a_ins_grows, cmd.finish && ok_reg && (kind_reg == KIND_INSERT), len_reg == $past(len_reg) + LEN_W'(1), "insert did not grow list")

endmodule

// File: rtl/core/ordered_array_list_engine.sv
// Ordering: items are handled one at a time; a new item is accepted only after
//   the previous one has left its done state.
// Shifts: the entry memory is read and then written once per shifted entry,
//   in separate controller states.
// Stall: a result held by rsp_ready low keeps the next item from finishing.
// Reset: rst_n async active low empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
// Ordered array list engine
// Positional word list with insert, remove and search over a shared memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_array_list_engine #(
    parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = oale_pkg::WORD_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  oale_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output oale_pkg::rsp_t rsp
);

    import oale_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    oale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    oale_dp #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
